// ===== design/dwd_pkg.sv =====
`timescale 1ns / 1ps
package dwd_pkg;

    // Mode codes carried on the input tuser
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BEGIN = 2'd1;
    localparam logic [1:0] MODE_DRAW  = 2'd2;

    // Work kinds handed from the front to the back
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_BEGIN  = 2'd1;
    localparam logic [1:0] KIND_DRAW   = 2'd2;
    localparam logic [1:0] KIND_REFUSE = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DRAWN   = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;

    // Configuration register indexes
    localparam logic [7:0] CFG_ENTRY_COUNT = 8'd0;
    localparam logic [7:0] CFG_SAMPLE_SIZE = 8'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  index;
        logic [15:0] weight;
        logic [31:0] uniform;
    } dwd_item_t;

endpackage

// ===== design/dwd_ram.sv =====
`timescale 1ns / 1ps
module dwd_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/dwd_front.sv =====
`timescale 1ns / 1ps
module dwd_front import dwd_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [5:0]  s_index,
    input  logic [15:0] s_weight,
    input  logic [31:0] s_uniform,
    input  logic        clearing,
    output logic        q_valid,
    output dwd_item_t   q_item,
    input  logic        q_pop
);

    logic [WEIGHT_BITS+15:0] w_ext;
    logic                    w_zero;
    logic                    idx_ok;
    dwd_item_t               in_item;
    dwd_item_t               ent_reg [2];
    logic                    wr_ptr_reg, wr_ptr_next;
    logic                    rd_ptr_reg, rd_ptr_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic                    push;

    assign w_ext  = {{WEIGHT_BITS{1'b0}}, s_weight};
    assign w_zero = (w_ext[WEIGHT_BITS-1:0] == '0);
    assign idx_ok = (32'(s_index) < MAX_ENTRIES);

    // Classify the item
    always_comb begin
        in_item.index   = s_index;
        in_item.weight  = s_weight;
        in_item.uniform = s_uniform;
        unique case (s_mode)
            MODE_LOAD:  in_item.kind = (!w_zero && idx_ok) ? KIND_LOAD : KIND_REFUSE;
            MODE_BEGIN: in_item.kind = KIND_BEGIN;
            MODE_DRAW:  in_item.kind = KIND_DRAW;
            default:    in_item.kind = KIND_REFUSE;
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2) && !clearing;
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = ent_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== design/dwd_back.sv =====
`timescale 1ns / 1ps
module dwd_back import dwd_pkg::*; #(
    parameter int MAX_ENTRIES  = 64,
    parameter int WEIGHT_BITS  = 16,
    parameter int UNIFORM_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [6:0] entry_count,
    input  logic [6:0] sample_size,
    input  logic       q_valid,
    input  dwd_item_t  q_item,
    output logic       q_pop,
    output logic       clearing,
    input  logic       m_ready,
    output logic       m_valid,
    output logic [5:0] m_index,
    output logic [1:0] m_status,
    output logic       m_done
);

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int SW  = WEIGHT_BITS + AW;
    localparam int PW  = SW + UNIFORM_BITS;
    localparam int UCW = $clog2(UNIFORM_BITS + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_THR   = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [AW-1:0]          rd_idx_reg, rd_idx_next;
    logic [PW-1:0]          acc_reg, acc_next;
    logic [UNIFORM_BITS-1:0] u_reg, u_next;
    logic [UCW-1:0]         mcnt_reg, mcnt_next;
    logic [SW-1:0]          rem_reg, rem_next;
    logic [SW-1:0]          th_reg, th_next;
    logic [SW-1:0]          run_reg, run_next;
    logic [6:0]             draws_reg, draws_next;
    logic [MAX_ENTRIES-1:0] marks_reg, marks_next;
    logic                   have_prev_reg, have_prev_next;
    logic [WEIGHT_BITS-1:0] pw_reg, pw_next;
    logic [AW-1:0]          pi_reg, pi_next;
    logic                   best_vld_reg, best_vld_next;
    logic [WEIGHT_BITS-1:0] bw_reg, bw_next;
    logic [AW-1:0]          bi_reg, bi_next;
    logic                   res_valid_reg, res_valid_next;
    logic [5:0]             res_idx_reg, res_idx_next;
    logic [1:0]             res_st_reg, res_st_next;
    logic                   res_done_reg, res_done_next;

    logic [CW-1:0]          n_use;
    logic                   issuing;
    logic                   pass_done;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WEIGHT_BITS-1:0] ram_wdata;
    logic [WEIGHT_BITS-1:0] rd_data;
    logic [WEIGHT_BITS+15:0] w_ext;
    logic [WEIGHT_BITS-1:0] load_w;
    logic [AW+5:0]          idx_ext;
    logic [AW+5:0]          sel_ext;
    logic                   cand;
    logic [SW-1:0]          run_sum;
    logic [SW:0]            th_calc;
    logic [SW-1:0]          bw_ext;
    logic [6:0]             draws_inc;

    assign n_use     = (32'(entry_count) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(entry_count);
    assign issuing   = ((state_reg == S_SUM) || (state_reg == S_SCAN)) && (ptr_reg != n_use);
    assign pass_done = !issuing && !rd_vld_reg;
    assign clearing  = (state_reg == S_CLEAR);

    assign w_ext   = {{WEIGHT_BITS{1'b0}}, q_item.weight};
    assign load_w  = w_ext[WEIGHT_BITS-1:0];
    assign idx_ext = {{AW{1'b0}}, q_item.index};
    assign sel_ext = {6'd0, bi_reg};
    assign bw_ext  = SW'(bw_reg);
    assign run_sum = run_reg + bw_ext;
    assign draws_inc = draws_reg + 7'd1;
    assign th_calc = {1'b0, acc_reg[PW-1:UNIFORM_BITS]} + (SW+1)'(|acc_reg[UNIFORM_BITS-1:0]);

    assign cand = rd_vld_reg && !marks_reg[rd_idx_reg] && (rd_data != '0) &&
                  (!have_prev_reg || (rd_data < pw_reg) ||
                   ((rd_data == pw_reg) && (rd_idx_reg > pi_reg)));

    dwd_ram #(
        .DATA_W (WEIGHT_BITS),
        .DEPTH  (MAX_ENTRIES)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issuing),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        rd_vld_next    = issuing;
        rd_idx_next    = ptr_reg[AW-1:0];
        acc_next       = acc_reg;
        u_next         = u_reg;
        mcnt_next      = mcnt_reg;
        rem_next       = rem_reg;
        th_next        = th_reg;
        run_next       = run_reg;
        draws_next     = draws_reg;
        marks_next     = marks_reg;
        have_prev_next = have_prev_reg;
        pw_next        = pw_reg;
        pi_next        = pi_reg;
        best_vld_next  = best_vld_reg;
        bw_next        = bw_reg;
        bi_next        = bi_reg;
        res_valid_next = res_valid_reg && !m_ready;
        res_idx_next   = res_idx_reg;
        res_st_next    = res_st_reg;
        res_done_next  = res_done_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = idx_ext[AW-1:0];
        ram_wdata      = load_w;

        if (issuing) begin
            ptr_next = ptr_reg + CW'(1);
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[AW-1:0];
                ram_wdata = '0;
                ptr_next  = ptr_reg + CW'(1);
                if (ptr_reg == CW'(MAX_ENTRIES - 1)) begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid && (!res_valid_reg || m_ready)) begin
                    q_pop        = 1'b1;
                    res_idx_next = 6'd0;
                    res_done_next = 1'b0;
                    unique case (q_item.kind)
                        KIND_LOAD: begin
                            ram_we         = 1'b1;
                            res_valid_next = 1'b1;
                            res_st_next    = STAT_OK;
                        end
                        KIND_BEGIN: begin
                            ptr_next   = '0;
                            acc_next   = '0;
                            state_next = S_SUM;
                        end
                        KIND_DRAW: begin
                            if ((draws_reg < sample_size) && (rem_reg != '0)) begin
                                acc_next   = '0;
                                u_next     = q_item.uniform[UNIFORM_BITS-1:0];
                                mcnt_next  = '0;
                                state_next = S_MUL;
                            end else begin
                                res_valid_next = 1'b1;
                                res_st_next    = STAT_REFUSED;
                            end
                        end
                        default: begin
                            res_valid_next = 1'b1;
                            res_st_next    = STAT_REFUSED;
                        end
                    endcase
                end
            end
            S_SUM: begin
                if (rd_vld_reg) begin
                    acc_next = acc_reg + PW'(rd_data);
                end
                if (pass_done) begin
                    rem_next       = acc_reg[SW-1:0];
                    draws_next     = 7'd0;
                    marks_next     = '0;
                    res_valid_next = 1'b1;
                    res_st_next    = STAT_OK;
                    state_next     = S_IDLE;
                end
            end
            S_MUL: begin
                acc_next  = {acc_reg[PW-2:0], 1'b0} +
                            (u_reg[UNIFORM_BITS-1] ? PW'(rem_reg) : '0);
                u_next    = u_reg << 1;
                mcnt_next = mcnt_reg + UCW'(1);
                if (mcnt_reg == UCW'(UNIFORM_BITS - 1)) begin
                    state_next = S_THR;
                end
            end
            S_THR: begin
                th_next        = th_calc[SW-1:0];
                ptr_next       = '0;
                run_next       = '0;
                have_prev_next = 1'b0;
                best_vld_next  = 1'b0;
                state_next     = S_SCAN;
            end
            S_SCAN: begin
                if (cand && (!best_vld_reg || (rd_data > bw_reg))) begin
                    best_vld_next = 1'b1;
                    bw_next       = rd_data;
                    bi_next       = rd_idx_reg;
                end
                if (pass_done) begin
                    if (!best_vld_reg) begin
                        res_valid_next = 1'b1;
                        res_st_next    = STAT_REFUSED;
                        state_next     = S_IDLE;
                    end else if (run_sum >= th_reg) begin
                        marks_next[bi_reg] = 1'b1;
                        rem_next       = (rem_reg > bw_ext) ? rem_reg - bw_ext : '0;
                        draws_next     = draws_inc;
                        res_valid_next = 1'b1;
                        res_st_next    = STAT_DRAWN;
                        res_idx_next   = sel_ext[5:0];
                        res_done_next  = (draws_inc == sample_size);
                        state_next     = S_IDLE;
                    end else begin
                        run_next       = run_sum;
                        have_prev_next = 1'b1;
                        pw_next        = bw_reg;
                        pi_next        = bi_reg;
                        best_vld_next  = 1'b0;
                        ptr_next       = '0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rem_reg       <= '0;
            draws_reg     <= 7'd0;
            marks_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rd_vld_reg    <= rd_vld_next;
            rem_reg       <= rem_next;
            draws_reg     <= draws_next;
            marks_reg     <= marks_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        acc_reg       <= acc_next;
        u_reg         <= u_next;
        mcnt_reg      <= mcnt_next;
        th_reg        <= th_next;
        run_reg       <= run_next;
        have_prev_reg <= have_prev_next;
        pw_reg        <= pw_next;
        pi_reg        <= pi_next;
        best_vld_reg  <= best_vld_next;
        bw_reg        <= bw_next;
        bi_reg        <= bi_next;
        res_idx_reg   <= res_idx_next;
        res_st_reg    <= res_st_next;
        res_done_reg  <= res_done_next;
    end

    assign m_valid  = res_valid_reg;
    assign m_index  = res_idx_reg;
    assign m_status = res_st_reg;
    assign m_done   = res_done_reg;

endmodule

// ===== design/weighted_draw_without_replacement_unit.sv =====
`timescale 1ns / 1ps
// Operation: load and refused items are answered from the idle state; begin sums the
//   n entries in use; draw runs a bit-serial threshold multiply on the uniform, then
//   one scan of the n entries per weight-ordered step, up to n steps.
// Throughput: one item at a time in the back end; the weight memory read port
//   (one entry per cycle) sets the scan time. The front queue holds two items.
// Reset: synchronous, active low; afterwards a clearing pass over all MAX_ENTRIES entries
//   zeroes the weight memory, with s_tready low until it ends.
module weighted_draw_without_replacement_unit import dwd_pkg::*; #(
    parameter int MAX_ENTRIES  = 64,
    parameter int WEIGHT_BITS  = 16,
    parameter int UNIFORM_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // entry_index[5:0], weight[21:6], uniform[53:22], zero pad
    input  logic [1:0]  s_tuser,    // mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // selected_index[5:0], zero pad
    output logic [1:0]  m_tuser,    // status
    output logic        m_tlast,    // sample_done
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_index,
    input  logic [6:0]  cfg_wr_data
);

    logic [6:0] entry_count_reg, entry_count_next;
    logic [6:0] sample_size_reg, sample_size_next;
    logic       q_valid;
    dwd_item_t  q_item;
    logic       q_pop;
    logic       clearing;
    logic [5:0] res_index;

    // Configuration registers; writes to unknown indexes are dropped
    always_comb begin
        entry_count_next = entry_count_reg;
        sample_size_next = sample_size_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENTRY_COUNT: entry_count_next = cfg_wr_data;
                CFG_SAMPLE_SIZE: sample_size_next = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= 7'd64;
            sample_size_reg <= 7'd1;
        end else begin
            entry_count_reg <= entry_count_next;
            sample_size_reg <= sample_size_next;
        end
    end

    // Front end: classify each transaction and hold it in a two-deep queue
    dwd_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_mode    (s_tuser),
        .s_index   (s_tdata[5:0]),
        .s_weight  (s_tdata[21:6]),
        .s_uniform (s_tdata[53:22]),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // Back end: weight memory, sum, threshold multiply and ordered scan
    dwd_back #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_count (entry_count_reg),
        .sample_size (sample_size_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .m_ready     (m_tready),
        .m_valid     (m_tvalid),
        .m_index     (res_index),
        .m_status    (m_tuser),
        .m_done      (m_tlast)
    );

    assign m_tdata = {2'b00, res_index};

endmodule
